// ===== design/assert_macros.svh =====
// assertion macros shared by the design files
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define SPQ_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define SPQ_ASSERT(label, prop)
`define SPQ_NEVER(label, cond)
`endif
`endif

// ===== design/spq_pkg.sv =====
// shared constants, codes and types of the sorted priority queue
// no dependencies
package spq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int PRI_W = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2,
    OP_POP    = 2'd3
  } spq_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } spq_status_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] pos;
  } spq_shift_t;

endpackage

// ===== design/spq_cell.sv =====
// one storage cell of the sorted chain: holds an entry, compares it, shifts
// depends on spq_pkg
module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk,
  input  logic                    load,
  input  logic [IDX_W-1:0]        idx,
  input  logic [CNT_W-1:0]        cnt,
  input  logic [VAL_W-1:0]        cmp_value,
  input  logic signed [PRI_W-1:0] cmp_priority,
  input  spq_shift_t              shift,
  input  logic [VAL_W-1:0]        new_value,
  input  logic signed [PRI_W-1:0] new_priority,
  input  logic [VAL_W-1:0]        prev_value,
  input  logic signed [PRI_W-1:0] prev_priority,
  input  logic [VAL_W-1:0]        next_value,
  input  logic signed [PRI_W-1:0] next_priority,
  output logic [VAL_W-1:0]        value,
  output logic signed [PRI_W-1:0] priority_q,
  output logic                    lt,
  output logic                    eq,
  output logic                    top
);

  logic occupied;
  logic is_top;

  assign occupied = CNT_W'(idx) < cnt;
  assign is_top   = (CNT_W'(idx) + CNT_W'(1)) == cnt;

  always_ff @(posedge clk) begin
    if (load) begin
      lt  <= occupied && (priority_q < cmp_priority);
      eq  <= occupied && (value == cmp_value);
      top <= is_top;
    end
    if (shift.ins) begin
      if (idx == shift.pos) begin
        value      <= new_value;
        priority_q <= new_priority;
      end else if (idx > shift.pos) begin
        value      <= prev_value;
        priority_q <= prev_priority;
      end
    end else if (shift.del && (idx >= shift.pos)) begin
      value      <= next_value;
      priority_q <= next_priority;
    end
  end

endmodule

// ===== design/spq_pick.sv =====
// encodes the selected cell's position and gathers its entry
// depends on spq_pkg
module spq_pick
  import spq_pkg::*;
(
  input  logic [DEPTH-1:0]             onehot,
  input  logic [DEPTH-1:0][VAL_W-1:0]  values,
  input  logic [DEPTH-1:0][PRI_W-1:0]  priorities,
  output logic                         hit,
  output logic [IDX_W-1:0]             pos,
  output logic [VAL_W-1:0]             sel_value,
  output logic [PRI_W-1:0]             sel_priority
);

  always_comb begin
    pos          = '0;
    sel_value    = '0;
    sel_priority = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (onehot[i]) begin
        pos          = pos | IDX_W'(i);
        sel_value    = sel_value | values[i];
        sel_priority = sel_priority | priorities[i];
      end
    end
  end

  assign hit = |onehot;

endmodule

// ===== design/sorted_priority_queue.sv =====
// top level of the sorted priority queue: control, cell chain, result register
// depends on spq_pkg, spq_cell, spq_pick and assert_macros.svh
//
//   channel  handshake           payload
//   in       in_valid/in_stall   opcode, item_value, item_priority
//   out      out_valid/out_stall status, out_value, out_priority,
//                                found_position, entry_total
//
// each operation runs through four steps: accept (cells compare), first-hit mask
// (one DEPTH-wide add), position and entry gather, then the chain update
// no clearing pass: only occupied cells are ever read, entry count resets to 0
// a result waiting on out_stall holds the update stage; in_stall stays high
`include "assert_macros.svh"
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic signed [31:0] item_value,
  input  logic signed [15:0] item_priority,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic signed [31:0] out_value,
  output logic signed [15:0] out_priority,
  output logic [5:0]        found_position,
  output logic [6:0]        entry_total
);

  typedef enum logic [1:0] {S_IDLE, S_ENC, S_SEL, S_APPLY} state_t;

  state_t                   state;
  spq_op_t                  op;
  logic [VAL_W-1:0]         op_value;
  logic signed [PRI_W-1:0]  op_priority;
  logic [CNT_W-1:0]         count;
  logic [DEPTH-1:0]         onehot;
  logic [DEPTH-1:0]         onehot_next;
  logic [DEPTH-1:0]         pick_src;
  logic                     hit;
  logic [IDX_W-1:0]         pos;
  logic [VAL_W-1:0]         sel_value;
  logic [PRI_W-1:0]         sel_priority;
  logic                     pick_hit;
  logic [IDX_W-1:0]         pick_pos;
  logic [VAL_W-1:0]         pick_value;
  logic [PRI_W-1:0]         pick_priority;

  logic [DEPTH-1:0][VAL_W-1:0] cell_value;
  logic [DEPTH-1:0][PRI_W-1:0] cell_priority;
  logic [DEPTH-1:0]            cell_lt;
  logic [DEPTH-1:0]            cell_eq;
  logic [DEPTH-1:0]            cell_top;

  logic        accept;
  logic        full;
  logic        apply_go;
  spq_shift_t  shift;
  logic [31:0] pos_wide;
  logic [31:0] cnt_wide;

  spq_status_t      status_next;
  logic [VAL_W-1:0] out_value_next;
  logic [PRI_W-1:0] out_priority_next;
  logic [5:0]       found_position_next;
  logic [6:0]       entry_total_next;
  logic [CNT_W-1:0] count_next;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign full     = (count == CNT_W'(DEPTH));
  assign apply_go = (state == S_APPLY) && (!out_valid || !out_stall);

  // insert goes before the first cell that is not lower in priority
  always_comb begin
    case (op)
      OP_INSERT: pick_src = ~cell_lt;
      OP_FIND:   pick_src = cell_eq;
      OP_DELETE: pick_src = cell_eq;
      OP_POP:    pick_src = cell_top;
      default:   pick_src = '0;
    endcase
  end

  // keep only the lowest set bit
  assign onehot_next = pick_src & (~pick_src + {{(DEPTH-1){1'b0}}, 1'b1});

  assign shift.ins = apply_go && (op == OP_INSERT) && !full;
  assign shift.del = apply_go && (op == OP_DELETE) && hit;
  assign shift.pos = pos;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0]        pv;
    logic signed [PRI_W-1:0] pp;
    logic [VAL_W-1:0]        nv;
    logic signed [PRI_W-1:0] np;
    logic signed [PRI_W-1:0] own_pri;

    if (g == 0) begin : g_first
      assign pv = op_value;
      assign pp = op_priority;
    end else begin : g_mid
      assign pv = cell_value[g-1];
      assign pp = cell_priority[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign nv = cell_value[g];
      assign np = cell_priority[g];
    end else begin : g_inner
      assign nv = cell_value[g+1];
      assign np = cell_priority[g+1];
    end
    assign cell_priority[g] = own_pri;

    spq_cell u_cell (
      .clk           (clk),
      .load          (accept),
      .idx           (IDX_W'(g)),
      .cnt           (count),
      .cmp_value     (item_value),
      .cmp_priority  (item_priority),
      .shift         (shift),
      .new_value     (op_value),
      .new_priority  (op_priority),
      .prev_value    (pv),
      .prev_priority (pp),
      .next_value    (nv),
      .next_priority (np),
      .value         (cell_value[g]),
      .priority_q    (own_pri),
      .lt            (cell_lt[g]),
      .eq            (cell_eq[g]),
      .top           (cell_top[g])
    );
  end

  spq_pick u_pick (
    .onehot       (onehot),
    .values       (cell_value),
    .priorities   (cell_priority),
    .hit          (pick_hit),
    .pos          (pick_pos),
    .sel_value    (pick_value),
    .sel_priority (pick_priority)
  );

  assign pos_wide = 32'(pos);

  // result beat and new entry count of the operation in the update stage
  always_comb begin
    status_next         = ST_OK;
    out_value_next      = '0;
    out_priority_next   = '0;
    found_position_next = '0;
    entry_total_next    = cnt_wide[6:0];
    count_next          = count;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          out_value_next      = op_value;
          out_priority_next   = op_priority;
          found_position_next = pos_wide[5:0];
          entry_total_next    = cnt_wide[6:0] + 7'd1;
          count_next          = count + CNT_W'(1);
        end
      end
      OP_FIND, OP_DELETE: begin
        out_value_next = op_value;
        if (!hit) begin
          status_next = ST_NOT_FOUND;
        end else begin
          out_priority_next   = sel_priority;
          found_position_next = pos_wide[5:0];
          if (op == OP_DELETE) begin
            entry_total_next = cnt_wide[6:0] - 7'd1;
            count_next       = count - CNT_W'(1);
          end
        end
      end
      OP_POP: begin
        if (!hit) begin
          status_next = ST_EMPTY;
        end else begin
          out_value_next      = sel_value;
          out_priority_next   = sel_priority;
          found_position_next = pos_wide[5:0];
          entry_total_next    = cnt_wide[6:0] - 7'd1;
          count_next          = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !apply_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op          <= spq_op_t'(opcode);
            op_value    <= item_value;
            op_priority <= item_priority;
            state       <= S_ENC;
          end
        end
        S_ENC: begin
          onehot <= onehot_next;
          state  <= S_SEL;
        end
        S_SEL: begin
          hit          <= pick_hit;
          pos          <= pick_pos;
          sel_value    <= pick_value;
          sel_priority <= pick_priority;
          state        <= S_APPLY;
        end
        S_APPLY: begin
          if (apply_go) begin
            out_valid      <= 1'b1;
            status         <= status_next;
            out_value      <= out_value_next;
            out_priority   <= out_priority_next;
            found_position <= found_position_next;
            entry_total    <= entry_total_next;
            count          <= count_next;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cnt_wide = 32'(count);

  `SPQ_NEVER(a_count_bound, count > CNT_W'(DEPTH))
  `SPQ_ASSERT(a_mask_onehot, (state == S_SEL) |-> $onehot0(onehot))
  `SPQ_ASSERT(a_accept_starts, accept |=> (state == S_ENC))
  `SPQ_ASSERT(a_insert_finds_slot,
              (state == S_SEL && op == OP_INSERT && !full) |-> (onehot != '0))
  `SPQ_ASSERT(a_result_waits,
              (state == S_APPLY && out_valid && out_stall) |=> (state == S_APPLY))

endmodule
